/* rtl/core/shm_pkg.sv */
package shm_pkg;

  // width of one character byte
  localparam int BYTE_W = 8;

  // hash width limits and defaults
  localparam int DEF_MAX_HASH_BITS = 20;
  localparam logic [4:0] MIN_HASH_BITS = 5'd8;
  localparam logic [4:0] RST_HASH_BITS = 5'd20;

  // width of both saturating counters
  localparam int COUNT_W = 31;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_INDEX_W-1:0] REG_HASH_MODE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HASH_BITS = 1'd1;

  // hash mode codes, any other code acts as sum
  localparam logic [1:0] MODE_SUM = 2'd0;
  localparam logic [1:0] MODE_PRODUCT = 2'd1;
  localparam logic [1:0] MODE_XOR = 2'd2;

endpackage

/* rtl/core/string_hash_collision_marker.sv */
// a word-end hash passes h1 (bitmap read), h2 (bitmap write), out_data; one byte per cycle
//   is taken while s_tready is high; the seen bitmap ram takes one read-modify-write per
//   word each cycle, with the write of the word ahead forwarded to the word behind
// reset: after rst the bitmap is cleared one entry a cycle, all 2^MAX_HASH_BITS entries
//   (1048576 at the default), with s_tready low; configuration writes are taken throughout
module string_hash_collision_marker #(
  parameter int MAX_HASH_BITS = shm_pkg::DEF_MAX_HASH_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  // input words
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [shm_pkg::BYTE_W-1:0]     s_tdata,   // char_byte
  input  logic                           s_tlast,   // word_end
  input  logic                           s_tuser,   // word_empty
  // result words
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [((MAX_HASH_BITS + 2*shm_pkg::COUNT_W + 1 + 7) / 8) * 8 - 1:0] m_tdata,
                                         // hash_value, collided, collision_total,
                                         // word_total, zero fill
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [shm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [shm_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int HW = MAX_HASH_BITS;
  localparam int CW = shm_pkg::COUNT_W;
  localparam int RES_W = HW + 2*CW + 1;
  localparam int OUT_W = ((RES_W + 7) / 8) * 8;
  localparam int FRAG_W = HW + shm_pkg::BYTE_W - 1;
  localparam int FILL_W = $clog2(FRAG_W + 1);
  localparam int FOLD_STEPS = FRAG_W / shm_pkg::BYTE_W;
  localparam int DEPTH = 1 << HW;

  // configuration registers
  logic [1:0] hash_mode;
  logic [4:0] hash_bits;

  // per-word accumulators
  logic [HW-1:0]     acc_sum;
  logic [HW-1:0]     acc_prod;
  logic [FRAG_W-1:0] frag;
  logic [FILL_W-1:0] fill;
  logic [HW-1:0]     xacc;

  // pipeline towards the bitmap
  logic          v1;
  logic [HW-1:0] h1;
  logic          v2;
  logic [HW-1:0] h2;
  logic          fwd2;

  // counters and output register
  logic [CW-1:0]    word_counter;
  logic [CW-1:0]    collision_counter;
  logic             out_valid;
  logic [OUT_W-1:0] out_data;

  // bitmap clearing after reset
  logic          clearing;
  logic [HW-1:0] clr_addr;

  // combinational values
  logic              ready0, ready1, ready2;
  logic              in_fire, take;
  logic [4:0]        n;
  logic [HW-1:0]     hmask;
  logic [FRAG_W-1:0] fmask;
  logic [HW-1:0]     sext;
  logic [HW-1:0]     sum_new, prod_new, xacc_new;
  logic [FRAG_W-1:0] frag_new;
  logic [FILL_W-1:0] fill_new;
  logic [HW-1:0]     h_word;
  logic              ram_we, ram_wdata, ram_re, ram_rdata;
  logic [HW-1:0]     ram_waddr;
  logic              hit;
  logic [CW-1:0]     word_counter_next, collision_counter_next;

  // handshakes
  assign ready2   = !out_valid || m_tready;
  assign ready1   = !v2 || ready2;
  assign ready0   = !v1 || ready1;
  assign s_tready = ready0 && !clearing;
  assign in_fire  = s_tvalid && s_tready;
  assign take     = in_fire && !s_tuser;
  assign cfg_ready = 1'b1;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // effective hash width, clamped into range
  always_comb begin
    if (hash_bits < shm_pkg::MIN_HASH_BITS) begin
      n = shm_pkg::MIN_HASH_BITS;
    end else if (hash_bits > 5'(HW)) begin
      n = 5'(HW);
    end else begin
      n = hash_bits;
    end
  end

  assign hmask = ~({HW{1'b1}} << n);
  assign fmask = ~({FRAG_W{1'b1}} << n);

  // sum and product updates
  assign sext     = HW'($signed(s_tdata));
  assign sum_new  = take ? acc_sum + sext : acc_sum;
  assign prod_new = take ? HW'(acc_prod * sext) : acc_prod;

  // xor-fold: shift in the byte, then fold out every complete fragment
  always_comb begin
    logic [FRAG_W-1:0] f;
    logic [FILL_W-1:0] c;
    logic [FILL_W-1:0] r;
    logic [HW-1:0]     x;
    f = frag;
    c = fill;
    x = xacc;
    r = '0;
    if (take) begin
      f = (frag << shm_pkg::BYTE_W) | FRAG_W'(s_tdata);
      c = fill + FILL_W'(shm_pkg::BYTE_W);
    end
    for (int i = 0; i < FOLD_STEPS; i++) begin
      if (take && (6'(c) >= 6'(n))) begin
        r = c - FILL_W'(n);
        x = x ^ HW'((f >> r) & fmask);
        f = f & ~({FRAG_W{1'b1}} << r);
        c = r;
      end
    end
    frag_new = f;
    fill_new = c;
    xacc_new = x;
  end

  // hash of the word that ends with this item
  always_comb begin
    unique case (hash_mode)
      shm_pkg::MODE_PRODUCT: h_word = prod_new & hmask;
      shm_pkg::MODE_XOR:     h_word = (xacc_new ^ HW'(frag_new)) & hmask;
      default:               h_word = sum_new & hmask;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_mode <= shm_pkg::MODE_SUM;
      hash_bits <= shm_pkg::RST_HASH_BITS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        shm_pkg::REG_HASH_MODE: hash_mode <= cfg_data[1:0];
        shm_pkg::REG_HASH_BITS: hash_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  // accumulators, restarted after each word end
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_sum  <= '0;
      acc_prod <= HW'(1);
      frag     <= '0;
      fill     <= '0;
      xacc     <= '0;
    end else if (in_fire) begin
      if (s_tlast) begin
        acc_sum  <= '0;
        acc_prod <= HW'(1);
        frag     <= '0;
        fill     <= '0;
        xacc     <= '0;
      end else begin
        acc_sum  <= sum_new;
        acc_prod <= prod_new;
        frag     <= frag_new;
        fill     <= fill_new;
        xacc     <= xacc_new;
      end
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready0) begin
        v1 <= in_fire && s_tlast;
      end
      if (ready1) begin
        v2 <= v1;
      end
      if (ready2) begin
        out_valid <= v2;
      end
    end
  end

  // pipeline payload; flag a write to the same entry landing as the read is made
  always_ff @(posedge clk) begin
    if (ready0) begin
      h1 <= h_word;
    end
    if (ready1) begin
      h2   <= h1;
      fwd2 <= v2 && (h2 == h1);
    end
  end

  // bitmap clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + HW'(1);
      if (clr_addr == {HW{1'b1}}) begin
        clearing <= 1'b0;
      end
    end
  end

  // bitmap ports
  assign ram_re    = v1 && ready1;
  assign ram_we    = clearing || (v2 && ready2);
  assign ram_waddr = clearing ? clr_addr : h2;
  assign ram_wdata = !clearing;

  shm_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_seen_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (h1),
    .rdata (ram_rdata)
  );

  // collision test and saturating counts
  assign hit = ram_rdata || fwd2;

  always_comb begin
    word_counter_next = word_counter;
    collision_counter_next = collision_counter;
    if (word_counter != {CW{1'b1}}) begin
      word_counter_next = word_counter + CW'(1);
    end
    if (hit && (collision_counter != {CW{1'b1}})) begin
      collision_counter_next = collision_counter + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_counter      <= '0;
      collision_counter <= '0;
    end else if (v2 && ready2) begin
      word_counter      <= word_counter_next;
      collision_counter <= collision_counter_next;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (v2 && ready2) begin
      out_data <= OUT_W'({word_counter_next, collision_counter_next, hit, h2});
    end
  end

endmodule

/* rtl/core/shm_ram.sv */
module shm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // registered read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

/* test/tb_string_hash_collision_marker.sv */
`timescale 1ns / 100ps

module tb_string_hash_collision_marker;

  localparam int HASH_W = shm_pkg::DEF_MAX_HASH_BITS;
  localparam int COUNT_W = shm_pkg::COUNT_W;
  localparam int RES_W = ((HASH_W + 2*COUNT_W + 1 + 7) / 8) * 8;
  localparam logic [COUNT_W-1:0] COUNT_TOP = '1;
  // code with no mode of its own, the block treats it as sum
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 250;
  localparam int MAX_REPORTS = 20;

  // result word as it sits in m_tdata, lowest field last
  typedef struct packed {
    logic [COUNT_W-1:0] words;
    logic [COUNT_W-1:0] collisions;
    logic               collided;
    logic [HASH_W-1:0]  hash;
  } hash_result_t;

  // tracks hash state, the seen bitmap and the counters
  class word_hash_tracker;
    logic [1:0]         mode;
    logic [4:0]         width_reg;
    logic [HASH_W-1:0]  sum_acc;
    logic [HASH_W-1:0]  prod_acc;
    logic [HASH_W-1:0]  xor_acc;
    logic [31:0]        frag_bits;
    int unsigned        frag_fill;
    bit                 seen_map [];
    logic [COUNT_W-1:0] word_count;
    logic [COUNT_W-1:0] collision_count;
    hash_result_t       pending_hashes [$];
    int unsigned        mismatches;
    int unsigned        checked;

    function new();
      seen_map = new[1 << HASH_W];
      mode = shm_pkg::MODE_SUM;
      width_reg = shm_pkg::RST_HASH_BITS;
      word_count = '0;
      collision_count = '0;
      mismatches = 0;
      checked = 0;
      restart_word();
    endfunction

    function void restart_word();
      sum_acc = '0;
      prod_acc = HASH_W'(1);
      xor_acc = '0;
      frag_bits = '0;
      frag_fill = 0;
    endfunction

    function void set_register(logic [shm_pkg::CFG_INDEX_W-1:0] index,
                               logic [shm_pkg::CFG_DATA_W-1:0] data);
      if (index == shm_pkg::REG_HASH_MODE) begin
        mode = data[1:0];
      end else begin
        width_reg = data;
      end
    endfunction

    // note one accepted input word, queue a result where it ends a string
    function void take_item(logic [7:0] char_byte, bit last, bit empty);
      int unsigned n;
      int unsigned rest;
      logic [HASH_W-1:0] sext;
      logic [HASH_W-1:0] h;
      hash_result_t r;
      n = (width_reg < shm_pkg::MIN_HASH_BITS) ? shm_pkg::MIN_HASH_BITS :
          (width_reg > HASH_W) ? HASH_W : width_reg;
      if (!empty) begin
        sext = {{(HASH_W-shm_pkg::BYTE_W){char_byte[7]}}, char_byte};
        sum_acc = sum_acc + sext;
        prod_acc = prod_acc * sext;
        // fold every full n-bit fragment into the xor hash
        frag_bits = ((frag_bits << 8) | char_byte) & 32'h7FFF_FFFF;
        frag_fill += 8;
        while (frag_fill >= n) begin
          rest = frag_fill - n;
          xor_acc ^= HASH_W'((frag_bits >> rest) & ((32'd1 << n) - 1));
          frag_bits &= (32'd1 << rest) - 1;
          frag_fill = rest;
        end
      end
      if (!last) return;
      case (mode)
        shm_pkg::MODE_PRODUCT: h = prod_acc;
        shm_pkg::MODE_XOR:     h = xor_acc ^ frag_bits[HASH_W-1:0];
        default:               h = sum_acc;
      endcase
      h &= HASH_W'((32'd1 << n) - 1);
      r.hash = h;
      r.collided = seen_map[h];
      seen_map[h] = 1'b1;
      if (word_count != COUNT_TOP) word_count++;
      if (r.collided && collision_count != COUNT_TOP) collision_count++;
      r.collisions = collision_count;
      r.words = word_count;
      pending_hashes.push_back(r);
      restart_word();
    endfunction

    function void report(string field, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t %s mismatch: expected %0h, got %0h", $time, field, want, got);
    endfunction

    // compare one accepted result word with the oldest expectation
    function void match_result(logic [RES_W-1:0] data);
      hash_result_t got;
      hash_result_t want;
      got = data[$bits(hash_result_t)-1:0];
      if (pending_hashes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t unexpected result: expected none, got %0h", $time, data);
        return;
      end
      want = pending_hashes.pop_front();
      checked++;
      if (want.hash !== got.hash) report("hash_value", want.hash, got.hash);
      if (want.collided !== got.collided) report("collided", want.collided, got.collided);
      if (want.collisions !== got.collisions)
        report("collision_total", want.collisions, got.collisions);
      if (want.words !== got.words) report("word_total", want.words, got.words);
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [shm_pkg::BYTE_W-1:0]      s_tdata;
  logic                            s_tlast;
  logic                            s_tuser;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [RES_W-1:0]                m_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [shm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [shm_pkg::CFG_DATA_W-1:0]  cfg_data;

  word_hash_tracker tracker = new();
  int unsigned tx_idle_pct = 19;
  int unsigned rx_idle_pct = 56;
  bit          hold_request = 1'b0;
  int unsigned items_sent = 0;
  logic [7:0]  prev_word [$];

  string_hash_collision_marker i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit, covers the bitmap clearing pass after reset
  initial begin
    #200_000_000;
    $display("tb: failure");
    $finish;
  end

  // result side back-pressure, with one long hold on request
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) tracker.match_result(m_tdata);
  end

  // offer one input word, with random gaps ahead of it
  task automatic send_char(logic [7:0] char_byte, bit last, bit empty);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= char_byte;
    s_tlast <= last;
    s_tuser <= empty;
    do @(posedge clk); while (s_tready !== 1'b1);
    tracker.take_item(char_byte, last, empty);
    if (!(empty && !last)) items_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic settle();
    s_tvalid <= 1'b0;
    while (tracker.pending_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write both registers back to back, only while idle
  task automatic configure(logic [1:0] mode, logic [4:0] width);
    cfg_valid <= 1'b1;
    cfg_index <= shm_pkg::REG_HASH_MODE;
    cfg_data <= {3'($urandom), mode};
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tracker.set_register(shm_pkg::REG_HASH_MODE, cfg_data);
    cfg_index <= shm_pkg::REG_HASH_BITS;
    cfg_data <= width;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tracker.set_register(shm_pkg::REG_HASH_BITS, cfg_data);
    cfg_valid <= 1'b0;
  endtask

  // one random string, sometimes a repeat, an empty one or a split ending
  task automatic send_word();
    int unsigned pick;
    int unsigned len;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 4) begin
      send_char(8'($urandom), 1'b1, 1'b1);
      return;
    end
    if (pick >= 14 || prev_word.size() == 0) begin
      prev_word.delete();
      len = $urandom_range(1, ($urandom_range(9) == 0) ? 30 : 8);
      repeat (len) begin
        b = 8'($urandom);
        if (tracker.mode == shm_pkg::MODE_PRODUCT && $urandom_range(1)) b[0] = 1'b1;
        prev_word.push_back(b);
      end
    end
    pick = $urandom_range(99);
    foreach (prev_word[i]) begin
      if ($urandom_range(99) < 3) send_char(8'($urandom), 1'b0, 1'b1);
      send_char(prev_word[i], (i == prev_word.size() - 1) && pick >= 5, 1'b0);
    end
    if (pick < 5) send_char(8'($urandom), 1'b1, 1'b1);
  endtask

  initial begin
    logic [1:0] phase_modes [8];
    int unsigned phase_start;
    phase_modes = '{shm_pkg::MODE_XOR, shm_pkg::MODE_SUM, shm_pkg::MODE_PRODUCT,
                    MODE_UNUSED, shm_pkg::MODE_XOR, shm_pkg::MODE_PRODUCT,
                    shm_pkg::MODE_SUM, shm_pkg::MODE_XOR};
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tlast <= 1'b0;
    s_tuser <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= shm_pkg::REG_HASH_MODE;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: sum over 20 bits, byte extremes, empty words, a repeat
    send_char(8'h00, 1'b1, 1'b1);
    send_char(8'h00, 1'b0, 1'b0);
    send_char(8'hFF, 1'b0, 1'b0);
    send_char(8'h55, 1'b0, 1'b1);
    send_char(8'h80, 1'b0, 1'b0);
    send_char(8'h7F, 1'b1, 1'b0);
    send_char(8'hAA, 1'b1, 1'b0);
    send_char(8'hAA, 1'b1, 1'b0);
    settle();

    // product, width below range, word closed by an empty end
    configure(shm_pkg::MODE_PRODUCT, 5'd0);
    send_char(8'hFF, 1'b0, 1'b0);
    send_char(8'h81, 1'b0, 1'b0);
    send_char(8'h03, 1'b1, 1'b1);
    send_char(8'h00, 1'b1, 1'b1);
    settle();

    // xor fold, width above range, then a string left open
    configure(shm_pkg::MODE_XOR, 5'd31);
    send_char(8'hFF, 1'b0, 1'b0);
    send_char(8'hA5, 1'b0, 1'b0);
    send_char(8'h5A, 1'b0, 1'b0);
    send_char(8'hC3, 1'b1, 1'b0);
    send_char(8'h12, 1'b0, 1'b0);
    send_char(8'h34, 1'b0, 1'b0);
    settle();

    // registers change inside that string, unused mode code
    configure(MODE_UNUSED, 5'd7);
    send_char(8'h56, 1'b1, 1'b0);
    send_char(8'hFF, 1'b0, 1'b0);
    send_char(8'hFF, 1'b1, 1'b0);
    settle();

    // xor fold at the narrowest width
    configure(shm_pkg::MODE_XOR, shm_pkg::MIN_HASH_BITS);
    send_char(8'h01, 1'b0, 1'b0);
    send_char(8'h80, 1'b0, 1'b0);
    send_char(8'hFF, 1'b1, 1'b0);
    settle();

    // random phases, idle pattern changes and one long result hold
    for (int p = 0; p < 8; p++) begin
      tx_idle_pct = (p < 3) ? 19 : (p < 6) ? 56 : 0;
      rx_idle_pct = (p < 3) ? 56 : (p < 6) ? 19 : 0;
      configure(phase_modes[p], (p % 2) ? 5'($urandom_range(8, 11)) : 5'($urandom_range(31)));
      if (p == 6) hold_request = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_word();
      // leave a string open across the next register change now and then
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) send_char(8'($urandom), 1'b0, 1'b0);
      end
      settle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d input words sent, %0d results checked, %0d collisions marked",
             items_sent, tracker.checked, tracker.collision_count);
    $display("modes sum, product, xor fold and the unused code, widths 0 to 31, open strings");
    if (tracker.mismatches == 0 && tracker.pending_hashes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
